// ===== rtl/khrc_pkg.sv =====
`default_nettype none

package khrc_pkg;

    // Default widths of the hit fields
    localparam int unsigned POS_BITS_DEF  = 31;
    localparam int unsigned NODE_BITS_DEF = 32;

    // Fixed widths of the emitted record
    localparam int unsigned QID_W   = 32;
    localparam int unsigned ONODE_W = 32;
    localparam int unsigned OPOS_W  = 31;
    localparam int unsigned COUNT_W = 31;
    localparam int unsigned MINM_W  = 31;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [MINM_W-1:0]  MIN_HITS_RST = MINM_W'(1);

    // Item kinds
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_HIT   = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Direction codes
    localparam logic [1:0] DIR_FLAT = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;

    // One emitted segment record
    typedef struct packed {
        logic [QID_W-1:0]          query_id;
        logic signed [ONODE_W-1:0] node;
        logic [OPOS_W-1:0]         first_qpos;
        logic [OPOS_W-1:0]         last_qpos;
        logic [OPOS_W-1:0]         first_npos;
        logic [OPOS_W-1:0]         last_npos;
        logic [COUNT_W-1:0]        count;
        logic [1:0]                node_dir;
        logic [1:0]                query_dir;
        logic                      passes_min;
        logic                      from_end;
    } t_rec;

endpackage

`default_nettype wire

// ===== rtl/kmer_hit_run_chainer_unit.sv =====
// A result enters the output register as the item that causes it is accepted, or the skid
// register if the output is stalled. One item per cycle while o_in_ready is high.
// A two-entry output buffer (output register plus skid register) keeps input flowing
// while one result waits; o_in_ready drops only while the skid register is full.
// Synchronous active-low reset closes the segment, zeroes the sequence id and
// sets the minimum hit count to 1; the configuration port is always ready.
`default_nettype none

module kmer_hit_run_chainer_unit #(
    parameter int unsigned POS_BITS  = khrc_pkg::POS_BITS_DEF,
    parameter int unsigned NODE_BITS = khrc_pkg::NODE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [khrc_pkg::MINM_W-1:0]         i_cfg_min_hits,
    // input items
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [1:0]                          i_op,
    input  wire logic [khrc_pkg::QID_W-1:0]          i_query_id,
    input  wire logic signed [NODE_BITS-1:0]         i_hit_node,
    input  wire logic [POS_BITS-1:0]                 i_hit_node_pos,
    input  wire logic [POS_BITS-1:0]                 i_hit_query_pos,
    // result items
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [khrc_pkg::QID_W-1:0]               o_out_query_id,
    output logic signed [khrc_pkg::ONODE_W-1:0]      o_out_node,
    output logic [khrc_pkg::OPOS_W-1:0]              o_first_query_pos,
    output logic [khrc_pkg::OPOS_W-1:0]              o_last_query_pos,
    output logic [khrc_pkg::OPOS_W-1:0]              o_first_npos,
    output logic [khrc_pkg::OPOS_W-1:0]              o_last_npos,
    output logic [khrc_pkg::COUNT_W-1:0]             o_match_count,
    output logic [1:0]                               o_node_dir,
    output logic [1:0]                               o_query_dir,
    output logic                                     o_passes_min,
    output logic                                     o_from_end
);

    // direction of last against first
    function automatic logic [1:0] dir_of(input logic [POS_BITS-1:0] first,
                                          input logic [POS_BITS-1:0] last);
        logic [1:0] d;
        if (last > first)      d = khrc_pkg::DIR_FWD;
        else if (last < first) d = khrc_pkg::DIR_BWD;
        else                   d = khrc_pkg::DIR_FLAT;
        return d;
    endfunction

    // absolute node id, modulo 2^NODE_BITS
    function automatic logic [NODE_BITS-1:0] magnitude(input logic [NODE_BITS-1:0] n);
        logic [NODE_BITS-1:0] m;
        if (n[NODE_BITS-1]) m = ~n + NODE_BITS'(1);
        else                m = n;
        return m;
    endfunction

    // segment state
    logic [khrc_pkg::MINM_W-1:0]  r_min_hits;
    logic [khrc_pkg::QID_W-1:0]   r_cur_query, n_cur_query;
    logic [NODE_BITS-1:0]         r_cur_node, n_cur_node;
    logic [POS_BITS-1:0]          r_first_qpos, n_first_qpos;
    logic [POS_BITS-1:0]          r_last_qpos, n_last_qpos;
    logic [POS_BITS-1:0]          r_first_npos, n_first_npos;
    logic [POS_BITS-1:0]          r_last_npos, n_last_npos;
    logic [khrc_pkg::COUNT_W-1:0] r_seg_count, n_seg_count;

    // output buffer
    logic            r_out_valid;
    logic            r_skid_valid;
    khrc_pkg::t_rec  r_out;
    khrc_pkg::t_rec  r_skid;

    logic            w_in_fire;
    logic            w_out_fire;
    logic            w_emit;
    logic            w_from_end;
    logic            w_open;
    logic            w_same;
    logic            w_keeps;
    logic [1:0]      w_seg_ndir;
    khrc_pkg::t_rec  w_rec;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ~r_skid_valid;
    assign w_in_fire   = i_in_valid & o_in_ready;
    assign w_out_fire  = r_out_valid & i_out_ready;

    // extend test for a hit against the open segment
    assign w_open     = (r_cur_node != '0);
    assign w_same     = (magnitude(r_cur_node) == magnitude(i_hit_node));
    assign w_seg_ndir = dir_of(r_first_npos, r_last_npos);

    always_comb begin
        case (w_seg_ndir)
            khrc_pkg::DIR_FWD: w_keeps = (i_hit_node_pos > r_last_npos);
            khrc_pkg::DIR_BWD: w_keeps = (i_hit_node_pos < r_last_npos);
            default:           w_keeps = 1'b1;
        endcase
    end

    // record of the open segment
    always_comb begin
        w_rec.query_id   = r_cur_query;
        w_rec.node       = khrc_pkg::ONODE_W'($signed(r_cur_node));
        w_rec.first_qpos = khrc_pkg::OPOS_W'(r_first_qpos);
        w_rec.last_qpos  = khrc_pkg::OPOS_W'(r_last_qpos);
        w_rec.first_npos = khrc_pkg::OPOS_W'(r_first_npos);
        w_rec.last_npos  = khrc_pkg::OPOS_W'(r_last_npos);
        w_rec.count      = r_seg_count;
        w_rec.node_dir   = w_seg_ndir;
        w_rec.query_dir  = dir_of(r_first_qpos, r_last_qpos);
        w_rec.passes_min = w_open && (r_seg_count >= r_min_hits);
        w_rec.from_end   = w_from_end;
    end

    // per-item state update
    always_comb begin
        n_cur_query  = r_cur_query;
        n_cur_node   = r_cur_node;
        n_first_qpos = r_first_qpos;
        n_last_qpos  = r_last_qpos;
        n_first_npos = r_first_npos;
        n_last_npos  = r_last_npos;
        n_seg_count  = r_seg_count;
        w_emit       = 1'b0;
        w_from_end   = 1'b0;
        case (i_op)
            khrc_pkg::OP_START: begin
                n_cur_query  = i_query_id;
                n_cur_node   = '0;
                n_first_qpos = '0;
                n_last_qpos  = '0;
                n_first_npos = '0;
                n_last_npos  = '0;
                n_seg_count  = '0;
            end
            khrc_pkg::OP_HIT: begin
                if (w_open && w_same && w_keeps) begin
                    if (r_seg_count != khrc_pkg::COUNT_MAX)
                        n_seg_count = r_seg_count + khrc_pkg::COUNT_W'(1);
                    n_last_npos = i_hit_node_pos;
                    n_last_qpos = i_hit_query_pos;
                end else begin
                    // break (if open) and open on this hit
                    w_emit       = w_open;
                    n_cur_node   = i_hit_node;
                    n_first_qpos = i_hit_query_pos;
                    n_last_qpos  = i_hit_query_pos;
                    n_first_npos = i_hit_node_pos;
                    n_last_npos  = i_hit_node_pos;
                    n_seg_count  = khrc_pkg::COUNT_W'(1);
                end
            end
            khrc_pkg::OP_END: begin
                if (w_open) begin
                    w_emit       = 1'b1;
                    w_from_end   = 1'b1;
                    n_cur_node   = '0;
                    n_first_qpos = '0;
                    n_last_qpos  = '0;
                    n_first_npos = '0;
                    n_last_npos  = '0;
                    n_seg_count  = '0;
                end
            end
            default: begin
                // unknown kind: no change
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_hits    <= khrc_pkg::MIN_HITS_RST;
            r_cur_query   <= '0;
            r_cur_node    <= '0;
            r_first_qpos  <= '0;
            r_last_qpos   <= '0;
            r_first_npos  <= '0;
            r_last_npos   <= '0;
            r_seg_count   <= '0;
        end else begin
            if (i_cfg_valid) r_min_hits <= i_cfg_min_hits;
            if (w_in_fire) begin
                r_cur_query  <= n_cur_query;
                r_cur_node   <= n_cur_node;
                r_first_qpos <= n_first_qpos;
                r_last_qpos  <= n_last_qpos;
                r_first_npos <= n_first_npos;
                r_last_npos  <= n_last_npos;
                r_seg_count  <= n_seg_count;
            end
        end
    end

    // output register and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_fire && w_emit) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid  <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) r_out <= r_skid;
        end else if (w_in_fire && w_emit) begin
            if (r_out_valid && !i_out_ready) r_skid <= w_rec;
            else                             r_out  <= w_rec;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_query_id    = r_out.query_id;
    assign o_out_node        = r_out.node;
    assign o_first_query_pos = r_out.first_qpos;
    assign o_last_query_pos  = r_out.last_qpos;
    assign o_first_npos      = r_out.first_npos;
    assign o_last_npos       = r_out.last_npos;
    assign o_match_count     = r_out.count;
    assign o_node_dir        = r_out.node_dir;
    assign o_query_dir       = r_out.query_dir;
    assign o_passes_min      = r_out.passes_min;
    assign o_from_end        = r_out.from_end;

`ifndef NO_ASSERTIONS
    // skid entry only ever sits behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // an open segment always holds at least one hit
    a_open_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_node != '0) |-> (r_seg_count != '0))
        else $error("open segment with zero count");

    // a result that meets a stalled output lands in the skid register
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_emit && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("result lost on a stalled output");

    // every emitted segment counts at least one hit
    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_match_count != '0))
        else $error("result with zero match count");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/khrc_seg_checker.sv =====
`default_nettype none

// Watches the three channels of the hit chainer, keeps its own copy of the
// open segment and compares every emitted segment record with the oldest
// predicted one.
module khrc_seg_checker (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_valid,
    input  wire logic                                   i_cfg_ready,
    input  wire logic [khrc_pkg::MINM_W-1:0]            i_cfg_min_hits,
    input  wire logic                                   i_in_valid,
    input  wire logic                                   i_in_ready,
    input  wire logic [1:0]                             i_op,
    input  wire logic [khrc_pkg::QID_W-1:0]             i_query_id,
    input  wire logic [khrc_pkg::NODE_BITS_DEF-1:0]     i_hit_node,
    input  wire logic [khrc_pkg::POS_BITS_DEF-1:0]      i_hit_node_pos,
    input  wire logic [khrc_pkg::POS_BITS_DEF-1:0]      i_hit_query_pos,
    input  wire logic                                   i_out_valid,
    input  wire logic                                   i_out_ready,
    input  wire khrc_pkg::t_rec                         i_seg,
    output int                                          o_pending,
    output int                                          o_errors
);

    // shadow of the segment state
    logic [khrc_pkg::QID_W-1:0]         cur_query;
    logic [khrc_pkg::NODE_BITS_DEF-1:0] open_node;
    logic [khrc_pkg::POS_BITS_DEF-1:0]  first_qpos, last_qpos, first_npos, last_npos;
    logic [khrc_pkg::COUNT_W-1:0]       hit_count;
    logic [khrc_pkg::MINM_W-1:0]        min_hits;

    khrc_pkg::t_rec seg_expect_q[$];
    int   errors = 0;

    function automatic logic [1:0] run_dir(
        input logic [khrc_pkg::POS_BITS_DEF-1:0] first,
        input logic [khrc_pkg::POS_BITS_DEF-1:0] last);
        if (last > first) return khrc_pkg::DIR_FWD;
        if (last < first) return khrc_pkg::DIR_BWD;
        return khrc_pkg::DIR_FLAT;
    endfunction

    task automatic clear_seg();
        open_node  = '0;
        first_qpos = '0;
        last_qpos  = '0;
        first_npos = '0;
        last_npos  = '0;
        hit_count  = '0;
    endtask

    task automatic open_seg(input logic [khrc_pkg::NODE_BITS_DEF-1:0] node,
                            input logic [khrc_pkg::POS_BITS_DEF-1:0] npos,
                            input logic [khrc_pkg::POS_BITS_DEF-1:0] qpos);
        open_node  = node;
        first_qpos = qpos;
        last_qpos  = qpos;
        first_npos = npos;
        last_npos  = npos;
        hit_count  = khrc_pkg::COUNT_W'(1);
    endtask

    // queue the record of the open segment
    task automatic push_seg(input logic from_end);
        khrc_pkg::t_rec rec;
        rec.query_id   = cur_query;
        rec.node       = open_node;
        rec.first_qpos = first_qpos;
        rec.last_qpos  = last_qpos;
        rec.first_npos = first_npos;
        rec.last_npos  = last_npos;
        rec.count      = hit_count;
        rec.node_dir   = run_dir(first_npos, last_npos);
        rec.query_dir  = run_dir(first_qpos, last_qpos);
        rec.passes_min = (open_node != '0) && (hit_count >= min_hits);
        rec.from_end   = from_end;
        seg_expect_q   = {seg_expect_q, rec};
    endtask

    // one accepted item through the chaining rules
    task automatic chain_item(input logic [1:0] op,
                              input logic [khrc_pkg::QID_W-1:0] qid,
                              input logic [khrc_pkg::NODE_BITS_DEF-1:0] node,
                              input logic [khrc_pkg::POS_BITS_DEF-1:0] npos,
                              input logic [khrc_pkg::POS_BITS_DEF-1:0] qpos);
        logic [khrc_pkg::NODE_BITS_DEF-1:0] mag_open, mag_hit;
        logic [1:0]                         dir;
        logic                               keeps;
        case (op)
            khrc_pkg::OP_START: begin
                // an open segment is dropped silently
                cur_query = qid;
                clear_seg();
            end
            khrc_pkg::OP_HIT: begin
                if (open_node == '0) begin
                    open_seg(node, npos, qpos);
                end else begin
                    // strand is ignored: compare magnitudes, modulo the width
                    mag_open = open_node[khrc_pkg::NODE_BITS_DEF-1] ?
                               ~open_node + khrc_pkg::NODE_BITS_DEF'(1) : open_node;
                    mag_hit  = node[khrc_pkg::NODE_BITS_DEF-1] ?
                               ~node + khrc_pkg::NODE_BITS_DEF'(1) : node;
                    dir = run_dir(first_npos, last_npos);
                    if (dir == khrc_pkg::DIR_FWD)      keeps = npos > last_npos;
                    else if (dir == khrc_pkg::DIR_BWD) keeps = npos < last_npos;
                    else                               keeps = 1'b1;
                    if (mag_open == mag_hit && keeps) begin
                        if (hit_count != khrc_pkg::COUNT_MAX)
                            hit_count = hit_count + khrc_pkg::COUNT_W'(1);
                        last_npos = npos;
                        last_qpos = qpos;
                    end else begin
                        push_seg(1'b0);
                        open_seg(node, npos, qpos);
                    end
                end
            end
            khrc_pkg::OP_END: begin
                if (open_node != '0) begin
                    push_seg(1'b1);
                    clear_seg();
                end
            end
            default: ;  // unknown kind: no effect
        endcase
    endtask

    task automatic cmp_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_seg(input khrc_pkg::t_rec want);
        cmp_field("out_query_id",    64'(want.query_id),   64'(i_seg.query_id));
        cmp_field("out_node",        64'(want.node),       64'(i_seg.node));
        cmp_field("first_query_pos", 64'(want.first_qpos), 64'(i_seg.first_qpos));
        cmp_field("last_query_pos",  64'(want.last_qpos),  64'(i_seg.last_qpos));
        cmp_field("first_npos",      64'(want.first_npos), 64'(i_seg.first_npos));
        cmp_field("last_npos",       64'(want.last_npos),  64'(i_seg.last_npos));
        cmp_field("match_count",     64'(want.count),      64'(i_seg.count));
        cmp_field("node_dir",        64'(want.node_dir),   64'(i_seg.node_dir));
        cmp_field("query_dir",       64'(want.query_dir),  64'(i_seg.query_dir));
        cmp_field("passes_min",      64'(want.passes_min), 64'(i_seg.passes_min));
        cmp_field("from_end",        64'(want.from_end),   64'(i_seg.from_end));
    endtask

    // predict on input items first, so a same-edge result would still find its entry;
    // a register write takes effect for later items only
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_hits  = khrc_pkg::MIN_HITS_RST;
            cur_query = '0;
            clear_seg();
            seg_expect_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                chain_item(i_op, i_query_id, i_hit_node, i_hit_node_pos, i_hit_query_pos);
            if (i_cfg_valid && i_cfg_ready) min_hits = i_cfg_min_hits;
            if (i_out_valid && i_out_ready) begin
                if (seg_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: no segment expected, got node %0h count %0h",
                             $time, i_seg.node, i_seg.count);
                end else begin
                    check_seg(seg_expect_q.pop_front());
                end
            end
        end
        o_pending <= seg_expect_q.size();
        o_errors  <= errors;
    end

endmodule

`default_nettype wire

// ===== tb/sv/kmer_hit_run_chainer_unit_tb.sv =====
`default_nettype none

module kmer_hit_run_chainer_unit_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 135;
    localparam int HOLD_CYCLES = 120;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic [khrc_pkg::MINM_W-1:0]         i_cfg_min_hits = '0;
    logic                                i_in_valid = 1'b0;
    logic [1:0]                          i_op = khrc_pkg::OP_START;
    logic [khrc_pkg::QID_W-1:0]          i_query_id = '0;
    logic [khrc_pkg::NODE_BITS_DEF-1:0]  i_hit_node = '0;
    logic [khrc_pkg::POS_BITS_DEF-1:0]   i_hit_node_pos = '0;
    logic [khrc_pkg::POS_BITS_DEF-1:0]   i_hit_query_pos = '0;
    logic                                i_out_ready = 1'b0;

    logic                                o_cfg_ready, o_in_ready, o_out_valid;
    logic [khrc_pkg::QID_W-1:0]          o_out_query_id;
    logic signed [khrc_pkg::ONODE_W-1:0] o_out_node;
    logic [khrc_pkg::OPOS_W-1:0]         o_first_query_pos, o_last_query_pos;
    logic [khrc_pkg::OPOS_W-1:0]         o_first_npos, o_last_npos;
    logic [khrc_pkg::COUNT_W-1:0]        o_match_count;
    logic [1:0]                          o_node_dir, o_query_dir;
    logic                                o_passes_min, o_from_end;

    khrc_pkg::t_rec seg_out;
    int   pending, errors;
    logic idle_on = 1'b1;
    int   hold_reqs = 0;
    int   items_sent = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    kmer_hit_run_chainer_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_min_hits    (i_cfg_min_hits),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_query_id        (i_query_id),
        .i_hit_node        (i_hit_node),
        .i_hit_node_pos    (i_hit_node_pos),
        .i_hit_query_pos   (i_hit_query_pos),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_query_id    (o_out_query_id),
        .o_out_node        (o_out_node),
        .o_first_query_pos (o_first_query_pos),
        .o_last_query_pos  (o_last_query_pos),
        .o_first_npos      (o_first_npos),
        .o_last_npos       (o_last_npos),
        .o_match_count     (o_match_count),
        .o_node_dir        (o_node_dir),
        .o_query_dir       (o_query_dir),
        .o_passes_min      (o_passes_min),
        .o_from_end        (o_from_end)
    );

    assign seg_out = {o_out_query_id, o_out_node, o_first_query_pos, o_last_query_pos,
                      o_first_npos, o_last_npos, o_match_count, o_node_dir,
                      o_query_dir, o_passes_min, o_from_end};

    khrc_seg_checker chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_min_hits    (i_cfg_min_hits),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_query_id        (i_query_id),
        .i_hit_node        (i_hit_node),
        .i_hit_node_pos    (i_hit_node_pos),
        .i_hit_query_pos   (i_hit_query_pos),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_seg             (seg_out),
        .o_pending         (pending),
        .o_errors          (errors)
    );

    // offer one item, with an occasional idle burst first; returns on acceptance
    task automatic put_item(input logic [1:0] op,
                            input logic [khrc_pkg::QID_W-1:0] qid,
                            input logic [khrc_pkg::NODE_BITS_DEF-1:0] node,
                            input logic [khrc_pkg::POS_BITS_DEF-1:0] npos,
                            input logic [khrc_pkg::POS_BITS_DEF-1:0] qpos);
        int gap;
        if (idle_on && $urandom_range(0, 11) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_query_id      <= qid;
        i_hit_node      <= node;
        i_hit_node_pos  <= npos;
        i_hit_query_pos <= qpos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // stop offering and wait until every predicted segment has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_min(input logic [khrc_pkg::MINM_W-1:0] value);
        drain();
        i_cfg_valid    <= 1'b1;
        i_cfg_min_hits <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial begin : sink
        int holds_done, n;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                holds_done++;
                i_out_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #8000000;
        $display("kmer_hit_run_chainer_unit: mismatch");
        $finish;
    end

    initial begin : stim
        int ph, target, n, s, k, nseg, len, stride;
        logic [khrc_pkg::MINM_W-1:0]        mm;
        logic [khrc_pkg::NODE_BITS_DEF-1:0] node;
        logic [khrc_pkg::POS_BITS_DEF-1:0]  npos, qpos;
        logic [1:0]                         ndir, qdir;

        node = khrc_pkg::NODE_BITS_DEF'(1);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes and corner cases, minimum hit count at reset value
        put_item(khrc_pkg::OP_HIT, '0, 32'd5, '0, '0);                 // hit before any start
        put_item(khrc_pkg::OP_START, '1, '0, '0, '0);                  // drops the open segment
        put_item(khrc_pkg::OP_HIT, '0, 32'h7fff_ffff, '1, '0);
        put_item(khrc_pkg::OP_HIT, '0, 32'h8000_0001, '0, '1);         // other strand, falling
        put_item(khrc_pkg::OP_HIT, '0, 32'h8000_0001, 31'd5, 31'd3);   // rising in falling run
        put_item(khrc_pkg::OP_HIT, '1, 32'h8000_0000, 31'd5, 31'd4);   // most negative node id
        put_item(khrc_pkg::OP_HIT, '0, 32'h8000_0000, 31'd5, 31'd2);   // flat run extends
        put_item(khrc_pkg::OP_HIT, '0, '0, 31'd9, 31'd9);              // node zero after a run
        put_item(khrc_pkg::OP_END, '0, '0, '0, '0);                    // nothing open
        put_item(OP_UNUSED, '1, '1, '1, '1);
        put_item(khrc_pkg::OP_END, '1, '1, '1, '1);
        put_item(khrc_pkg::OP_HIT, '0, 32'd7, 31'd10, 31'd1);          // after end, no start
        put_item(khrc_pkg::OP_HIT, '0, 32'd7, 31'd11, 31'd2);
        put_item(khrc_pkg::OP_HIT, '0, 32'd7, 31'd11, 31'd3);          // equal pos breaks run
        put_item(khrc_pkg::OP_END, '0, '0, '0, '0);
        put_item(khrc_pkg::OP_START, '0, '1, '1, '1);
        put_item(khrc_pkg::OP_HIT, '0, 32'hffff_fffd, 31'd100, 31'd50);
        put_item(khrc_pkg::OP_HIT, '0, 32'd3, 31'd100, 31'd40);
        put_item(khrc_pkg::OP_END, '0, '0, '0, '0);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       mm = '1;
                1:       mm = '0;
                2:       mm = khrc_pkg::MINM_W'(2);
                3:       mm = khrc_pkg::MINM_W'(3);
                4:       mm = khrc_pkg::MINM_W'($urandom_range(1, 6));
                5:       mm = khrc_pkg::MINM_W'($urandom());
                default: mm = khrc_pkg::MINM_W'($urandom_range(1, 4));
            endcase
            write_min(mm);
            if (ph == PHASES - 1) idle_on <= 1'b0;

            // long hold-off on the result side while hits keep breaking runs
            if (ph == 2) begin
                hold_reqs <= hold_reqs + 1;
                for (k = 0; k < 40; k++)
                    put_item(khrc_pkg::OP_HIT, '0, (k % 2) ? 32'd11 : 32'd12,
                             khrc_pkg::POS_BITS_DEF'(k), khrc_pkg::POS_BITS_DEF'(k));
            end

            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(0, 6) == 0) begin
                    // loose items of any kind
                    n = $urandom_range(1, 4);
                    repeat (n) put_item(2'($urandom_range(0, 3)), $urandom(), $urandom(),
                                        khrc_pkg::POS_BITS_DEF'($urandom()),
                                        khrc_pkg::POS_BITS_DEF'($urandom()));
                end else begin
                    // one read: start, runs of colinear hits, usually an end
                    put_item(khrc_pkg::OP_START, $urandom(), $urandom(),
                             khrc_pkg::POS_BITS_DEF'($urandom()),
                             khrc_pkg::POS_BITS_DEF'($urandom()));
                    nseg = $urandom_range(1, 6);
                    for (s = 0; s < nseg; s++) begin
                        case ($urandom_range(0, 9))
                            0: node = '0;
                            1: node = ~node + khrc_pkg::NODE_BITS_DEF'(1); // other strand
                            2: ;                      // same node again
                            3: begin
                                node = $urandom_range(1, 8);
                                if ($urandom_range(0, 1))
                                    node = ~node + khrc_pkg::NODE_BITS_DEF'(1);
                            end
                            default: node = $urandom();
                        endcase
                        if ($urandom_range(0, 3) == 0) begin
                            npos = khrc_pkg::POS_BITS_DEF'($urandom());
                            qpos = khrc_pkg::POS_BITS_DEF'($urandom());
                        end else begin
                            npos = khrc_pkg::POS_BITS_DEF'($urandom_range(0, 1000));
                            qpos = khrc_pkg::POS_BITS_DEF'($urandom_range(0, 1000));
                        end
                        ndir = 2'($urandom_range(0, 2));
                        qdir = 2'($urandom_range(0, 2));
                        len  = $urandom_range(1, 8);
                        for (k = 0; k < len; k++) begin
                            put_item(khrc_pkg::OP_HIT, $urandom(), node, npos, qpos);
                            stride = $urandom_range(1, 3);
                            if ($urandom_range(0, 9) == 0)
                                npos = khrc_pkg::POS_BITS_DEF'($urandom_range(0, 1000));
                            else if (ndir == khrc_pkg::DIR_FWD)
                                npos = npos + khrc_pkg::POS_BITS_DEF'(stride);
                            else if (ndir == khrc_pkg::DIR_BWD)
                                npos = npos - khrc_pkg::POS_BITS_DEF'(stride);
                            if (qdir == khrc_pkg::DIR_FWD)
                                qpos = qpos + khrc_pkg::POS_BITS_DEF'(stride);
                            else if (qdir == khrc_pkg::DIR_BWD)
                                qpos = qpos - khrc_pkg::POS_BITS_DEF'(stride);
                        end
                    end
                    if ($urandom_range(0, 4) != 0)
                        put_item(khrc_pkg::OP_END, $urandom(), $urandom(),
                                 khrc_pkg::POS_BITS_DEF'($urandom()),
                                 khrc_pkg::POS_BITS_DEF'($urandom()));
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("kmer_hit_run_chainer_unit: match");
        end else begin
            $display("kmer_hit_run_chainer_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
